@@ sv/inertia_tensor_check_and_invert_core_defines.svh @@
// Assertion macros shared by the inertia tensor inverter.
`ifndef INERTIA_TENSOR_CHECK_AND_INVERT_CORE_DEFINES_SVH
`define INERTIA_TENSOR_CHECK_AND_INVERT_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ITCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ITCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/itci_pkg.sv @@
package itci_pkg;

    // Field and datapath widths.
    localparam int ENT_W   = 32;
    localparam int NUM_ENT = 9;
    localparam int ST_W    = 3;
    localparam int PROD_W  = 2 * ENT_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int DET_W   = 98;
    localparam int DIV_STEPS = ENT_W;
    localparam int LANE_LAT  = DIV_STEPS + 1;
    localparam int IN_W    = NUM_ENT * ENT_W;
    localparam int OUT_RAW_W = NUM_ENT * ENT_W + ST_W;
    localparam int OUT_W   = ((OUT_RAW_W + 7) / 8) * 8;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_ASYM     = 3'd1;
    localparam logic [ST_W-1:0] ST_DIAG     = 3'd2;
    localparam logic [ST_W-1:0] ST_TRIANGLE = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_DEF  = 3'd4;
    localparam logic [ST_W-1:0] ST_SAT      = 3'd5;

    // Control that travels with a word through the pipeline.
    typedef struct packed {
        logic            valid;
        logic [ST_W-1:0] status;
    } t_ctl;

endpackage

@@ sv/inertia_tensor_check_and_invert_core.sv @@
// Inertia tensor check and inverse.
// Input stream (s_axis): one word per 3x3 tensor of nine signed Q16.16
// entries. Output stream (m_axis): one word per input word with the nine
// inverse entries (adjugate over determinant, truncated toward zero,
// saturated) and a status code; on a failed check the entries are zero.
// Throughput: one word per cycle while the skid buffer is empty; every word is independent.
// Path from acceptance to o_m_axis_tvalid: 7 front stages (checks, cofactor
// products, cofactors, determinant), then 32 restoring-division stages, one
// quotient bit each, plus a clamp stage in each of nine parallel lanes, then
// the output register.
// Reset (i_rst_n low, synchronous) empties the pipeline and output.
// When the receiver stalls, the output register holds its word and a
// one-word skid buffer catches the word leaving the pipeline; while the skid
// is full the whole pipeline holds and o_s_axis_tready is low.
`include "inertia_tensor_check_and_invert_core_defines.svh"

module inertia_tensor_check_and_invert_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 32 bits each
    input  logic [itci_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // inv00 .. inv22 (32 bits each) from bit 0 up, status (3 bits), zero fill
    output logic [itci_pkg::OUT_W-1:0]     o_m_axis_tdata
);

    localparam int NE = itci_pkg::NUM_ENT;
    localparam int EW = itci_pkg::ENT_W;

    logic r_skid_valid;
    logic w_en;
    assign w_en = !r_skid_valid;

    // Front: checks, cofactors and determinant.
    itci_pkg::t_ctl                  w_front_ctl;
    logic [itci_pkg::DET_W-1:0]      w_det;
    logic [itci_pkg::COF_W-1:0]      w_mag [NE];
    logic                            w_neg [NE];
    logic                            w_ovf [NE];

    itci_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_ctl   (w_front_ctl),
        .o_det   (w_det),
        .o_mag   (w_mag),
        .o_neg   (w_neg),
        .o_ovf   (w_ovf)
    );

    // Nine division lanes, one per inverse entry; the adjugate transposes.
    logic [EW-1:0] w_val [NE];
    logic          w_sat [NE];

    for (genvar g = 0; g < NE; g++) begin : g_lane
        itci_div_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_mag (w_mag[(g % 3) * 3 + g / 3]),
            .i_neg (w_neg[(g % 3) * 3 + g / 3]),
            .i_ovf (w_ovf[(g % 3) * 3 + g / 3]),
            .i_det (w_det),
            .o_val (w_val[g]),
            .o_sat (w_sat[g])
        );
    end

    itci_pkg::t_ctl w_pipe_ctl;
    logic [EW-1:0]  w_inv [NE];

    itci_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_front_ctl),
        .i_val   (w_val),
        .i_sat   (w_sat),
        .o_ctl   (w_pipe_ctl),
        .o_inv   (w_inv)
    );

    // Pack the result word.
    logic [itci_pkg::OUT_W-1:0] w_word;

    always_comb begin
        w_word = '0;
        for (int i = 0; i < NE; i++) begin
            w_word[i*EW +: EW] = w_inv[i];
        end
        w_word[NE*EW +: itci_pkg::ST_W] = w_pipe_ctl.status;
    end

    // Output register with one-word skid buffer.
    logic                       r_out_valid;
    logic [itci_pkg::OUT_W-1:0] r_out_data;
    logic [itci_pkg::OUT_W-1:0] r_skid_data;
    logic                       w_out_ready;
    assign w_out_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_pipe_ctl.valid;
            end
        end else if (w_pipe_ctl.valid && w_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_word;
        end else if (w_en) begin
            r_skid_data <= w_word;
        end
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A parked word always has a word in front of it.
    `ITCI_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with empty output")

    // A stalled output with a word leaving the pipeline fills the skid.
    `ITCI_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, r_out_valid && !i_m_axis_tready && w_pipe_ctl.valid && w_en, r_skid_valid, "word leaving pipeline was lost")

    // Failed checks deliver an all-zero inverse.
    `ITCI_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, r_out_valid && r_out_data[NE*EW +: itci_pkg::ST_W] != itci_pkg::ST_OK && r_out_data[NE*EW +: itci_pkg::ST_W] != itci_pkg::ST_SAT, r_out_data[NE*EW-1:0] == '0, "failed check with nonzero inverse")

    // Status never leaves the defined codes.
    `ITCI_ASSERT_NOW(a_status_range, i_clk, i_rst_n, r_out_valid, r_out_data[NE*EW +: itci_pkg::ST_W] <= itci_pkg::ST_SAT, "undefined status code")

endmodule

@@ sv/itci_front.sv @@
module itci_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [itci_pkg::IN_W-1:0]             i_data,
    output itci_pkg::t_ctl                        o_ctl,
    output logic [itci_pkg::DET_W-1:0]            o_det,
    output logic [itci_pkg::COF_W-1:0]            o_mag [itci_pkg::NUM_ENT],
    output logic                                  o_neg [itci_pkg::NUM_ENT],
    output logic                                  o_ovf [itci_pkg::NUM_ENT]
);

    localparam int EW = itci_pkg::ENT_W;
    localparam int NE = itci_pkg::NUM_ENT;
    localparam int PW = itci_pkg::PROD_W;
    localparam int CW = itci_pkg::COF_W;
    localparam int DW = itci_pkg::DET_W;

    // Unpack the word and run the structural checks in check order.
    logic signed [EW-1:0] w_m [NE];
    logic [itci_pkg::ST_W-1:0] n_st;

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            w_m[i] = $signed(i_data[i*EW +: EW]);
        end
        if (w_m[1] != w_m[3] || w_m[2] != w_m[6] || w_m[5] != w_m[7]) begin
            n_st = itci_pkg::ST_ASYM;
        end else if (w_m[0] <= 0 || w_m[4] <= 0 || w_m[8] <= 0) begin
            n_st = itci_pkg::ST_DIAG;
        end else if ((EW+1)'(w_m[0]) + (EW+1)'(w_m[4]) < (EW+1)'(w_m[8]) ||
                     (EW+1)'(w_m[0]) + (EW+1)'(w_m[8]) < (EW+1)'(w_m[4]) ||
                     (EW+1)'(w_m[4]) + (EW+1)'(w_m[8]) < (EW+1)'(w_m[0])) begin
            n_st = itci_pkg::ST_TRIANGLE;
        end else begin
            n_st = itci_pkg::ST_OK;
        end
    end

    // Stage A: registered entries and check status.
    logic                      r_a_v;
    logic [itci_pkg::ST_W-1:0] r_a_st;
    logic signed [EW-1:0]      r_a_m [NE];

    // Stage B: the two products of every cofactor.
    logic                      r_b_v;
    logic [itci_pkg::ST_W-1:0] r_b_st;
    logic signed [PW-1:0]      r_b_p [NE];
    logic signed [PW-1:0]      r_b_s [NE];
    logic signed [EW-1:0]      r_b_r0 [3];
    logic signed [PW-1:0]      n_p [NE];
    logic signed [PW-1:0]      n_s [NE];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_p[r*3+c] = r_a_m[((r+1)%3)*3 + (c+1)%3] * r_a_m[((r+2)%3)*3 + (c+2)%3];
                n_s[r*3+c] = r_a_m[((r+1)%3)*3 + (c+2)%3] * r_a_m[((r+2)%3)*3 + (c+1)%3];
            end
        end
    end

    // Stage C: cofactors.
    logic                      r_c_v;
    logic [itci_pkg::ST_W-1:0] r_c_st;
    logic signed [CW-1:0]      r_c_cof [NE];
    logic signed [EW-1:0]      r_c_r0 [3];

    // Stage D: partial products of the first-row expansion, cofactor magnitudes.
    logic                      r_d_v;
    logic [itci_pkg::ST_W-1:0] r_d_st;
    logic signed [CW-1:0]      r_d_lo [3];
    logic signed [CW-1:0]      r_d_hi [3];
    logic [CW-1:0]             r_d_mag [NE];
    logic                      r_d_neg [NE];

    // Stage E: one determinant term per column.
    logic                      r_e_v;
    logic [itci_pkg::ST_W-1:0] r_e_st;
    logic signed [DW-1:0]      r_e_t [3];
    logic [CW-1:0]             r_e_mag [NE];
    logic                      r_e_neg [NE];

    // Stage F: determinant.
    logic                      r_f_v;
    logic [itci_pkg::ST_W-1:0] r_f_st;
    logic signed [DW-1:0]      r_f_det;
    logic [CW-1:0]             r_f_mag [NE];
    logic                      r_f_neg [NE];

    // Stage G: definiteness check and per-entry overflow flags.
    logic                      r_g_v;
    logic [itci_pkg::ST_W-1:0] r_g_st;
    logic [DW-1:0]             r_g_det;
    logic [CW-1:0]             r_g_mag [NE];
    logic                      r_g_neg [NE];
    logic                      r_g_ovf [NE];

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_st <= n_st;
            r_b_st <= r_a_st;
            r_c_st <= r_b_st;
            r_d_st <= r_c_st;
            r_e_st <= r_d_st;
            r_f_st <= r_e_st;
            if (r_f_st == itci_pkg::ST_OK && (r_f_det[DW-1] || r_f_det == '0)) begin
                r_g_st <= itci_pkg::ST_NOT_DEF;
            end else begin
                r_g_st <= r_f_st;
            end
            for (int i = 0; i < NE; i++) begin
                r_a_m[i]   <= w_m[i];
                r_b_p[i]   <= n_p[i];
                r_b_s[i]   <= n_s[i];
                r_c_cof[i] <= CW'(r_b_p[i]) - CW'(r_b_s[i]);
                r_d_neg[i] <= r_c_cof[i][CW-1];
                r_d_mag[i] <= r_c_cof[i][CW-1] ? CW'(-r_c_cof[i]) : CW'(r_c_cof[i]);
                r_e_mag[i] <= r_d_mag[i];
                r_e_neg[i] <= r_d_neg[i];
                r_f_mag[i] <= r_e_mag[i];
                r_f_neg[i] <= r_e_neg[i];
                r_g_mag[i] <= r_f_mag[i];
                r_g_neg[i] <= r_f_neg[i];
                r_g_ovf[i] <= DW'(r_f_mag[i]) >= r_f_det;
            end
            for (int c = 0; c < 3; c++) begin
                r_b_r0[c] <= r_a_m[c];
                r_c_r0[c] <= r_b_r0[c];
                r_d_lo[c] <= CW'(r_c_r0[c]) * $signed({33'd0, r_c_cof[c][EW-1:0]});
                r_d_hi[c] <= CW'(r_c_r0[c]) * CW'($signed(r_c_cof[c][CW-1:EW]));
                r_e_t[c]  <= (DW'(r_d_hi[c]) <<< EW) + DW'(r_d_lo[c]);
            end
            r_f_det <= r_e_t[0] + r_e_t[1] + r_e_t[2];
            r_g_det <= r_f_det;
        end
    end

    assign o_ctl.valid  = r_g_v;
    assign o_ctl.status = r_g_st;
    assign o_det        = r_g_det;
    assign o_mag        = r_g_mag;
    assign o_neg        = r_g_neg;
    assign o_ovf        = r_g_ovf;

endmodule

@@ sv/itci_div_lane.sv @@
module itci_div_lane (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [itci_pkg::COF_W-1:0]        i_mag,
    input  logic                              i_neg,
    input  logic                              i_ovf,
    input  logic [itci_pkg::DET_W-1:0]        i_det,
    output logic [itci_pkg::ENT_W-1:0]        o_val,
    output logic                              o_sat
);

    localparam int NS = itci_pkg::DIV_STEPS;
    localparam int DW = itci_pkg::DET_W;
    localparam int EW = itci_pkg::ENT_W;

    // One quotient bit per stage; the dividend's low bits are all zero.
    logic [DW-1:0] r_rem [NS];
    logic [EW-1:0] r_q   [NS];
    logic [DW-1:0] r_det [NS];
    logic          r_neg [NS];
    logic          r_ovf [NS];
    logic [DW-1:0] n_rem [NS];
    logic [EW-1:0] n_q   [NS];

    always_comb begin
        logic [DW-1:0] prev_rem;
        logic [EW-1:0] prev_q;
        logic [DW-1:0] prev_det;
        logic [DW-1:0] shifted;
        for (int k = 0; k < NS; k++) begin
            prev_rem = (k == 0) ? DW'(i_mag) : r_rem[(k == 0) ? 0 : k-1];
            prev_q   = (k == 0) ? '0 : r_q[(k == 0) ? 0 : k-1];
            prev_det = (k == 0) ? i_det : r_det[(k == 0) ? 0 : k-1];
            shifted  = {prev_rem[DW-2:0], 1'b0};
            if (shifted >= prev_det) begin
                n_rem[k] = shifted - prev_det;
                n_q[k]   = {prev_q[EW-2:0], 1'b1};
            end else begin
                n_rem[k] = shifted;
                n_q[k]   = {prev_q[EW-2:0], 1'b0};
            end
        end
    end

    // Saturate and apply the sign in the last stage.
    logic [EW-1:0] r_val;
    logic          r_sat;
    logic [EW-1:0] w_q;
    assign w_q = r_q[NS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_det[k] <= (k == 0) ? i_det : r_det[(k == 0) ? 0 : k-1];
                r_neg[k] <= (k == 0) ? i_neg : r_neg[(k == 0) ? 0 : k-1];
                r_ovf[k] <= (k == 0) ? i_ovf : r_ovf[(k == 0) ? 0 : k-1];
            end
            if (!r_neg[NS-1]) begin
                if (r_ovf[NS-1] || w_q > 32'h7FFF_FFFF) begin
                    r_val <= 32'h7FFF_FFFF;
                    r_sat <= 1'b1;
                end else begin
                    r_val <= w_q;
                    r_sat <= 1'b0;
                end
            end else begin
                if (r_ovf[NS-1] || w_q > 32'h8000_0000) begin
                    r_val <= 32'h8000_0000;
                    r_sat <= 1'b1;
                end else begin
                    r_val <= EW'(-w_q);
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule

@@ sv/itci_merge.sv @@
module itci_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  itci_pkg::t_ctl                    i_ctl,
    input  logic [itci_pkg::ENT_W-1:0]        i_val [itci_pkg::NUM_ENT],
    input  logic                              i_sat [itci_pkg::NUM_ENT],
    output itci_pkg::t_ctl                    o_ctl,
    output logic [itci_pkg::ENT_W-1:0]        o_inv [itci_pkg::NUM_ENT]
);

    localparam int LAT = itci_pkg::LANE_LAT;
    localparam int NE  = itci_pkg::NUM_ENT;

    // Control delay line matching the lane latency.
    logic                      r_v  [LAT];
    logic [itci_pkg::ST_W-1:0] r_st [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < LAT; k++) begin
                r_v[k] <= (k == 0) ? i_ctl.valid : r_v[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LAT; k++) begin
                r_st[k] <= (k == 0) ? i_ctl.status : r_st[(k == 0) ? 0 : k-1];
            end
        end
    end

    // A failed check clears the inverse; otherwise any clamped lane flags the word.
    logic w_any_sat;

    always_comb begin
        w_any_sat = 1'b0;
        for (int i = 0; i < NE; i++) begin
            w_any_sat = w_any_sat | i_sat[i];
        end
        o_ctl.valid = r_v[LAT-1];
        if (r_st[LAT-1] != itci_pkg::ST_OK) begin
            o_ctl.status = r_st[LAT-1];
            for (int i = 0; i < NE; i++) begin
                o_inv[i] = '0;
            end
        end else begin
            o_ctl.status = w_any_sat ? itci_pkg::ST_SAT : itci_pkg::ST_OK;
            for (int i = 0; i < NE; i++) begin
                o_inv[i] = i_val[i];
            end
        end
    end

endmodule

@@ tb/tb_inertia_tensor_check_and_invert_core.sv @@
`timescale 1ns / 100ps

module tb_inertia_tensor_check_and_invert_core;

    // Position and width of the status field in a result word.
    localparam int ST_LSB = 32 * itci_pkg::NUM_ENT;
    localparam int SW     = itci_pkg::ST_W;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_axis_tvalid;
    logic                         o_s_axis_tready;
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 32 bits each
    logic [itci_pkg::IN_W-1:0]    i_s_axis_tdata;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready;
    // inv00 .. inv22 (32 bits each) from bit 0 up, status (3 bits), zero fill
    logic [itci_pkg::OUT_W-1:0]   o_m_axis_tdata;

    logic [itci_pkg::IN_W-1:0]    pending_tensors[$];
    logic [itci_pkg::OUT_W-1:0]   expected_inverses[$];
    int                           tensors_sent;
    int                           inverses_checked;
    int                           error_count;
    int                           status_seen[8];
    int                           sender_idle_pct;
    int                           receiver_idle_pct;
    logic                         o_s_axis_tready_seen;

    inertia_tensor_check_and_invert_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Expected inverse word for one tensor word: checks in order, then
    // adjugate over determinant with exact wide arithmetic.
    function automatic logic [itci_pkg::OUT_W-1:0] invert_tensor(
        logic [itci_pkg::IN_W-1:0] w);
        longint                      m[3][3];
        logic signed [127:0]         cof[3][3];
        logic signed [127:0]         a, b, c, d, det, num;
        logic [127:0]                quo;
        logic [SW-1:0]               st;
        logic [31:0]                 val;
        logic [itci_pkg::OUT_W-1:0]  res;
        bit                          neg;
        int                          r1, r2, c1, c2;
        res = '0;
        st = itci_pkg::ST_OK;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                m[r][k] = $signed(w[32*(3*r+k) +: 32]);
            end
        end
        if (m[0][1] != m[1][0] || m[0][2] != m[2][0] || m[1][2] != m[2][1]) begin
            st = itci_pkg::ST_ASYM;
        end else if (m[0][0] <= 0 || m[1][1] <= 0 || m[2][2] <= 0) begin
            st = itci_pkg::ST_DIAG;
        end else if (m[0][0] + m[1][1] < m[2][2] || m[0][0] + m[2][2] < m[1][1] ||
                     m[1][1] + m[2][2] < m[0][0]) begin
            st = itci_pkg::ST_TRIANGLE;
        end
        if (st != itci_pkg::ST_OK) begin
            res[ST_LSB +: SW] = st;
            return res;
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                r1 = (r + 1) % 3;
                r2 = (r + 2) % 3;
                c1 = (k + 1) % 3;
                c2 = (k + 2) % 3;
                a = m[r1][c1];
                b = m[r2][c2];
                c = m[r1][c2];
                d = m[r2][c1];
                cof[r][k] = a * b - c * d;
            end
        end
        det = 0;
        for (int k = 0; k < 3; k++) begin
            a = m[0][k];
            det = det + a * cof[0][k];
        end
        if (det <= 0) begin
            res[ST_LSB +: SW] = itci_pkg::ST_NOT_DEF;
            return res;
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                num = cof[r][k];
                neg = num < 0;
                if (neg) begin
                    num = -num;
                end
                quo = (128'(num) << 32) / 128'(det);
                if (!neg) begin
                    if (quo > 128'h7fff_ffff) begin
                        val = 32'h7fff_ffff;
                        st = itci_pkg::ST_SAT;
                    end else begin
                        val = quo[31:0];
                    end
                end else begin
                    if (quo > 128'h8000_0000) begin
                        val = 32'h8000_0000;
                        st = itci_pkg::ST_SAT;
                    end else begin
                        val = -quo[31:0];
                    end
                end
                // The adjugate is the transposed cofactor matrix.
                res[32*(3*k+r) +: 32] = val;
            end
        end
        res[ST_LSB +: SW] = st;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h, expected %h",
                 inverses_checked, what, got, want);
        error_count++;
    endtask

    task automatic add_tensor(int m00, int m01, int m02, int m10, int m11, int m12,
                              int m20, int m21, int m22);
        logic [itci_pkg::IN_W-1:0] w;
        w = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
        pending_tensors.push_back(w);
    endtask

    task automatic add_symmetric(int d0, int d1, int d2, int o01, int o02, int o12);
        add_tensor(d0, o01, o02, o01, d1, o12, o02, o12, d2);
    endtask

    function automatic int rand_mag();
        return int'($urandom >> $urandom_range(1, 31));
    endfunction

    function automatic int rand_signed();
        int v;
        v = rand_mag();
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    // Sender: present the next tensor word once the previous one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready_seen) begin
            if (pending_tensors.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
                i_s_axis_tdata  <= pending_tensors.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        if (i_rst_n) begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Acceptance of an input word as seen at the rising edge.
    always @(posedge i_clk) begin
        o_s_axis_tready_seen <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            expected_inverses.push_back(invert_tensor(i_s_axis_tdata));
            tensors_sent++;
        end
    end

    // Monitor: compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        logic [itci_pkg::OUT_W-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_inverses.size() == 0) begin
                $display("MISMATCH unexpected result word %h", o_m_axis_tdata);
                error_count++;
            end else begin
                want = expected_inverses.pop_front();
                for (int k = 0; k < itci_pkg::NUM_ENT; k++) begin
                    if (o_m_axis_tdata[32*k +: 32] !== want[32*k +: 32]) begin
                        report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3),
                                        o_m_axis_tdata[32*k +: 32], want[32*k +: 32]);
                    end
                end
                if (o_m_axis_tdata[ST_LSB +: SW] !== want[ST_LSB +: SW]) begin
                    report_mismatch("status", 32'(o_m_axis_tdata[ST_LSB +: SW]),
                                    32'(want[ST_LSB +: SW]));
                end
                status_seen[want[ST_LSB +: SW]]++;
            end
            inverses_checked++;
        end
    end

    // Stimulus, idle phases and the end of the run.
    initial begin
        int kind;
        int d;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        o_s_axis_tready_seen = 1'b0;
        tensors_sent = 0;
        inverses_checked = 0;
        error_count = 0;
        sender_idle_pct = 15;
        receiver_idle_pct = 61;

        // Directed: identity, each check failing, singular, saturation, extremes.
        add_symmetric(32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
        add_symmetric(32'h20000, 32'h30000, 32'h40000, 32'h8000, -32'h4000, 32'h1000);
        add_tensor(32'h10000, 1, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
        add_tensor(32'h10000, 0, 5, 0, 32'h10000, 0, 0, 0, 32'h10000);
        add_tensor(32'h10000, 0, 0, 0, 32'h10000, -7, 0, 0, 32'h10000);
        add_symmetric(0, 32'h10000, 32'h10000, 0, 0, 0);
        add_symmetric(32'h10000, -1, 32'h10000, 0, 0, 0);
        add_symmetric(32'h10000, 32'h10000, 32'h8000_0000, 0, 0, 0);
        add_symmetric(32'h10000, 32'h10000, 32'h30000, 0, 0, 0);
        add_symmetric(32'h50000, 32'h10000, 32'h10000, 0, 0, 0);
        add_symmetric(32'h10000, 32'h50000, 32'h10000, 0, 0, 0);
        add_symmetric(32'h10000, 32'h10000, 32'h20000, 0, 0, 0);
        add_symmetric(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
        add_symmetric(32'h10000, 32'h10000, 32'h10000, 32'h20000, 0, 0);
        add_symmetric(1, 1, 1, 0, 0, 0);
        add_symmetric(2, 3, 4, 1, 0, 1);
        add_symmetric(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
        add_symmetric(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_symmetric(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_0000, -32'h7fff_0000, 32'h3fff_0000);
        add_symmetric(32'h100, 32'h100, 32'h100, 32'hff, 0, 0);
        add_tensor(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000);
        add_tensor(-1, -1, -1, -1, -1, -1, -1, -1, -1);

        // Random: mostly well-formed symmetric tensors, some broken, some noise.
        for (int n = 0; n < 450; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                d = $urandom_range(1, 30);
                add_symmetric(int'($urandom >> d) + 1 + int'($urandom_range(0, 3)),
                              int'($urandom >> d) + 1, int'($urandom >> d) + 1,
                              rand_signed() >>> ($urandom_range(0, 1) * 4),
                              rand_signed(), rand_signed());
            end else if (kind < 90) begin
                add_tensor(rand_mag() + 1, rand_signed(), rand_signed(), rand_signed(),
                           rand_mag() + 1, rand_signed(), rand_signed(), rand_signed(),
                           rand_mag() + 1);
            end else begin
                add_tensor($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (tensors_sent >= 160);
        sender_idle_pct = 61;
        receiver_idle_pct = 15;
        wait (tensors_sent >= 320);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;

        wait (pending_tensors.size() == 0 && !i_s_axis_tvalid);
        wait (expected_inverses.size() == 0);
        repeat (60) @(posedge i_clk);

        $display("Checked %0d inverse words from %0d tensors.", inverses_checked,
                 tensors_sent);
        $display("Status mix: ok %0d, asym %0d, diag %0d, triangle %0d, not def %0d, sat %0d",
                 status_seen[itci_pkg::ST_OK], status_seen[itci_pkg::ST_ASYM],
                 status_seen[itci_pkg::ST_DIAG], status_seen[itci_pkg::ST_TRIANGLE],
                 status_seen[itci_pkg::ST_NOT_DEF], status_seen[itci_pkg::ST_SAT]);
        if (error_count == 0 && expected_inverses.size() == 0) begin
            $display("tb_inertia_tensor_check_and_invert_core: done, clean");
        end else begin
            $display("tb_inertia_tensor_check_and_invert_core: done, errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("Timeout with %0d words still expected.", expected_inverses.size());
        $display("tb_inertia_tensor_check_and_invert_core: done, errors");
        $finish;
    end

endmodule
